// ===== design/fpqr_pkg.sv =====
// Shared types, register indexes and reset defaults of the false position root finder.
package fpqr_pkg;

  // Default number format: signed Q15.16.
  localparam int DEF_VALUE_WIDTH   = 32;
  localparam int DEF_FRACTION_BITS = 16;

  // Register reset values; the coefficients are whole numbers scaled at elaboration.
  localparam int DEF_LINEAR_WHOLE   = -46;
  localparam int DEF_CONSTANT_WHOLE = -45;
  localparam int DEF_TOLERANCE      = 655;
  localparam int DEF_LIMIT          = 100;

  // Fixed field widths.
  localparam int TOL_W       = 16;
  localparam int TOL_FRAC    = 16;
  localparam int COUNT_W     = 8;
  localparam int OUTCOME_W   = 2;
  localparam int REG_INDEX_W = 2;

  // Configuration register indexes.
  typedef enum logic [REG_INDEX_W-1:0] {
    REG_COEFF_LINEAR    = 2'd0,
    REG_COEFF_CONSTANT  = 2'd1,
    REG_REL_TOLERANCE   = 2'd2,
    REG_ITERATION_LIMIT = 2'd3
  } reg_index_t;

  // Result status codes.
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_CONVERGED = 2'd0,
    OUT_EXACT     = 2'd1,
    OUT_NO_SIGN   = 2'd2,
    OUT_LIMIT     = 2'd3
  } outcome_t;

  // Operations of the shared shift-add / shift-subtract unit.
  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_stat_t;

  // Which point a polynomial evaluation belongs to.
  typedef enum logic [1:0] {
    EV_FIRST  = 2'd0,
    EV_SECOND = 2'd1,
    EV_EST    = 2'd2
  } eval_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQ_WAIT,
    S_LIN_WAIT,
    S_ADD1,
    S_ADD2,
    S_SIGN,
    S_ITER,
    S_PMUL_WAIT,
    S_DIV_WAIT,
    S_UPDATE,
    S_TOL,
    S_TOL_WAIT,
    S_OUT
  } state_t;

endpackage

// ===== design/fpqr_mdu.sv =====
// Shared radix-2 unit: unsigned shift-add multiply and restoring divide, one bit per cycle.
module fpqr_mdu #(
  parameter int VALUE_WIDTH = fpqr_pkg::DEF_VALUE_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fpqr_pkg::mdu_cmd_t         cmd,
  input  logic [VALUE_WIDTH-1:0]     opa,
  input  logic [VALUE_WIDTH-1:0]     opb,
  output fpqr_pkg::mdu_stat_t        stat,
  output logic [2*VALUE_WIDTH-1:0]   acc
);
  import fpqr_pkg::*;

  localparam int W     = VALUE_WIDTH;
  localparam int CNT_W = $clog2(W);

  mdu_op_t          op_q;
  logic [W-1:0]     opnd;
  logic [CNT_W-1:0] steps;
  logic             busy;
  logic             done;
  logic [W:0]       add_a;
  logic [W:0]       add_b;
  logic [W+1:0]     sum;
  logic [W-1:0]     rem_next;
  logic [2*W-1:0]   acc_next;
  logic             last_step;

  // One adder serves both operations: add for multiply, subtract for divide.
  always_comb begin
    if (op_q == MDU_MUL) begin
      add_a = {1'b0, acc[2*W-1:W]};
      add_b = acc[0] ? {1'b0, opnd} : '0;
    end else begin
      add_a = {acc[2*W-1:W], acc[W-1]};
      add_b = ~{1'b0, opnd};
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {{(W+1){1'b0}}, (op_q == MDU_DIV)};
  end

  // Next accumulator: shift right for multiply, shift left with quotient bit for divide.
  always_comb begin
    rem_next = sum[W+1] ? sum[W-1:0] : add_a[W-1:0];
    if (op_q == MDU_MUL) begin
      acc_next = {sum[W:0], acc[W-1:1]};
    end else begin
      acc_next = {rem_next, acc[W-2:0], sum[W+1]};
    end
  end

  assign last_step = (steps == CNT_W'(W - 1));

  // Control: busy for exactly W steps, then a one-cycle done flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && last_step) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: a divide keeps the accumulator as its dividend.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q  <= cmd.op;
      opnd  <= opa;
      steps <= '0;
      if (cmd.op == MDU_MUL) begin
        acc <= {{W{1'b0}}, opb};
      end
    end else if (busy) begin
      acc   <= acc_next;
      steps <= steps + 1'b1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== design/fpqr_regs.sv =====
// APB-style configuration registers: coefficients, tolerance and iteration limit.
module fpqr_regs #(
  parameter int VALUE_WIDTH   = fpqr_pkg::DEF_VALUE_WIDTH,
  parameter int FRACTION_BITS = fpqr_pkg::DEF_FRACTION_BITS,
  parameter int CFG_W         = 32,
  parameter int ADDR_W        = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ADDR_W-1:0]           paddr,
  input  logic [CFG_W-1:0]            pwdata,
  output logic [CFG_W-1:0]            prdata,
  output logic                        pready,
  output logic [VALUE_WIDTH-1:0]      coeff_linear,
  output logic [VALUE_WIDTH-1:0]      coeff_constant,
  output logic [fpqr_pkg::TOL_W-1:0]  rel_tolerance,
  output logic [fpqr_pkg::COUNT_W-1:0] iteration_limit
);
  import fpqr_pkg::*;

  localparam int W        = VALUE_WIDTH;
  localparam int ADDR_LSB = ADDR_W - REG_INDEX_W;
  localparam logic [W-1:0] RST_LINEAR =
    W'(longint'(DEF_LINEAR_WHOLE) * (longint'(1) <<< FRACTION_BITS));
  localparam logic [W-1:0] RST_CONSTANT =
    W'(longint'(DEF_CONSTANT_WHOLE) * (longint'(1) <<< FRACTION_BITS));

  reg_index_t index;
  logic       write_en;

  assign index    = reg_index_t'(paddr[ADDR_W-1:ADDR_LSB]);
  assign pready   = 1'b1;
  assign write_en = psel && penable && pwrite && pready;

  // Register writes on the access cycle of a write transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_linear    <= RST_LINEAR;
      coeff_constant  <= RST_CONSTANT;
      rel_tolerance   <= TOL_W'(DEF_TOLERANCE);
      iteration_limit <= COUNT_W'(DEF_LIMIT);
    end else if (write_en) begin
      case (index)
        REG_COEFF_LINEAR:    coeff_linear    <= pwdata[W-1:0];
        REG_COEFF_CONSTANT:  coeff_constant  <= pwdata[W-1:0];
        REG_REL_TOLERANCE:   rel_tolerance   <= pwdata[TOL_W-1:0];
        REG_ITERATION_LIMIT: iteration_limit <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    case (index)
      REG_COEFF_LINEAR:    prdata = CFG_W'(coeff_linear);
      REG_COEFF_CONSTANT:  prdata = CFG_W'(coeff_constant);
      REG_REL_TOLERANCE:   prdata = CFG_W'(rel_tolerance);
      REG_ITERATION_LIMIT: prdata = CFG_W'(iteration_limit);
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== design/false_position_quadratic_root.sv =====
// Top level: false position root finder for x*x + b*x + c over a bracketing interval.
//
// Usage: each transfer on the slave stream carries two interval endpoints in signed
// fixed point. The block evaluates the polynomial at both ends; without a sign change it
// returns status "no sign change" with a zero estimate and zero count. Otherwise it
// iterates secant estimates until an exact zero, until the interval width is within the
// relative tolerance of the second endpoint, or until the iteration limit, and returns
// one transfer on the master stream: estimate, iteration count and status.
// Coefficients, tolerance and limit sit in APB registers; they must be written only
// between items, which the block itself does not enforce. All multiplies and the divide
// share one radix-2 unit. s_tready is high only while the block waits for an item.
// The result sits in an output register, so the next item is taken while it waits;
// a stalled receiver holds a finished item only at its final step.
// Reset returns the sequencer to idle, drops m_tvalid and loads the register defaults.
module false_position_quadratic_root #(
  parameter int VALUE_WIDTH   = fpqr_pkg::DEF_VALUE_WIDTH,
  parameter int FRACTION_BITS = fpqr_pkg::DEF_FRACTION_BITS,
  localparam int CFG_W  = (VALUE_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_W = fpqr_pkg::REG_INDEX_W + ((VALUE_WIDTH > 32) ? 3 : 2),
  localparam int IN_W   = ((2 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W  =
    ((VALUE_WIDTH + fpqr_pkg::COUNT_W + fpqr_pkg::OUTCOME_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  // Input stream; tdata from bit 0: end_first, end_second, zero padding.
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,
  // Result stream; tdata from bit 0: root_estimate, iteration_count, outcome, padding.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);
  import fpqr_pkg::*;

  localparam int W = VALUE_WIDTH;
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  // Magnitude of a signed value; the most negative value maps to 2^(W-1).
  function automatic logic [W-1:0] abs_val(input logic [W-1:0] v);
    abs_val = v[W-1] ? -v : v;
  endfunction

  // Signed add saturating to the value range.
  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      sat_add = s[W] ? VMIN : VMAX;
    end else begin
      sat_add = s[W-1:0];
    end
  endfunction

  state_t   state;
  state_t   state_next;
  eval_t    eval_sel;
  outcome_t result;

  logic [W-1:0] coeff_linear;
  logic [W-1:0] coeff_constant;
  logic [TOL_W-1:0]   rel_tolerance;
  logic [COUNT_W-1:0] iteration_limit;

  logic [W-1:0] x1, x2, x0, xe;
  logic [W-1:0] f1, f2, f0;
  logic [W-1:0] term_sq, term_lin, fsum;
  logic [COUNT_W-1:0] count;

  mdu_cmd_t       mdu_cmd;
  mdu_stat_t      mdu_stat;
  logic [W-1:0]   mdu_a, mdu_b;
  logic [2*W-1:0] mdu_acc;

  logic           accept;
  logic           out_free;
  logic [2*W-1:0] prod_q;
  logic           scale_neg;
  logic           scale_ovf;
  logic [W-1:0]   scaled;
  logic [W:0]     span_raw, span_abs;
  logic           span_neg;
  logic [W-1:0]   span_mag;
  logic [W:0]     den_raw, den_abs;
  logic [W-1:0]   den_mag;
  logic [W:0]     x0_raw;
  logic [W-1:0]   x0_calc;
  logic [W-1:0]   f_new;
  logic           tol_ok;
  logic           same_sign;
  logic           opposite;

  // Configuration registers.
  fpqr_regs #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .CFG_W         (CFG_W),
    .ADDR_W        (ADDR_W)
  ) u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .coeff_linear    (coeff_linear),
    .coeff_constant  (coeff_constant),
    .rel_tolerance   (rel_tolerance),
    .iteration_limit (iteration_limit)
  );

  // Shared multiply / divide unit.
  fpqr_mdu #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mdu (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mdu_cmd),
    .opa  (mdu_a),
    .opb  (mdu_b),
    .stat (mdu_stat),
    .acc  (mdu_acc)
  );

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Product rescale: drop the fraction bits, then saturate with the product's sign.
  assign prod_q    = mdu_acc >> FRACTION_BITS;
  assign scale_neg = (state == S_LIN_WAIT) && (coeff_linear[W-1] ^ xe[W-1]);
  always_comb begin
    if (scale_neg) begin
      scale_ovf = (|prod_q[2*W-1:W]) || (prod_q[W-1] && (|prod_q[W-2:0]));
      scaled    = scale_ovf ? VMIN : -prod_q[W-1:0];
    end else begin
      scale_ovf = |prod_q[2*W-1:W-1];
      scaled    = scale_ovf ? VMAX : prod_q[W-1:0];
    end
  end

  // Interval span, secant denominator and new estimate.
  always_comb begin
    span_raw = {x2[W-1], x2} - {x1[W-1], x1};
    span_neg = span_raw[W];
    span_abs = span_neg ? -span_raw : span_raw;
    span_mag = span_abs[W-1:0];
    den_raw  = {f1[W-1], f1} - {f2[W-1], f2};
    den_abs  = den_raw[W] ? -den_raw : den_raw;
    den_mag  = den_abs[W-1:0];
    if (span_neg) begin
      x0_raw = {x1[W-1], x1} - {1'b0, mdu_acc[W-1:0]};
    end else begin
      x0_raw = {x1[W-1], x1} + {1'b0, mdu_acc[W-1:0]};
    end
    x0_calc = x0_raw[W-1:0];
  end

  assign f_new     = sat_add(fsum, coeff_constant);
  assign tol_ok    = ({{(W-TOL_FRAC){1'b0}}, span_mag, {TOL_FRAC{1'b0}}} <= mdu_acc);
  assign same_sign = (f1 != '0) && (f2 != '0) && (f1[W-1] == f2[W-1]);
  assign opposite  = (f1 != '0) && (f1[W-1] != f0[W-1]);

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (accept) state_next = S_SQ;
      S_SQ:        state_next = S_SQ_WAIT;
      S_SQ_WAIT:   if (mdu_stat.done) state_next = S_LIN_WAIT;
      S_LIN_WAIT:  if (mdu_stat.done) state_next = S_ADD1;
      S_ADD1:      state_next = S_ADD2;
      S_ADD2: begin
        case (eval_sel)
          EV_FIRST:  state_next = S_SQ;
          EV_SECOND: state_next = S_SIGN;
          default:   state_next = S_UPDATE;
        endcase
      end
      S_SIGN:      state_next = same_sign ? S_OUT : S_ITER;
      S_ITER:      state_next = (den_mag == '0) ? S_SQ : S_PMUL_WAIT;
      S_PMUL_WAIT: if (mdu_stat.done) state_next = S_DIV_WAIT;
      S_DIV_WAIT:  if (mdu_stat.done) state_next = S_SQ;
      S_UPDATE:    state_next = (f0 == '0) ? S_OUT : S_TOL;
      S_TOL:       state_next = S_TOL_WAIT;
      S_TOL_WAIT: begin
        if (mdu_stat.done) begin
          state_next = (tol_ok || (count >= iteration_limit)) ? S_OUT : S_ITER;
        end
      end
      S_OUT:       if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Sequencer: commands and operands for the shared unit.
  always_comb begin
    mdu_cmd.start = 1'b0;
    mdu_cmd.op    = MDU_MUL;
    mdu_a         = '0;
    mdu_b         = '0;
    case (state)
      S_SQ: begin
        mdu_cmd.start = 1'b1;
        mdu_a         = abs_val(xe);
        mdu_b         = abs_val(xe);
      end
      S_SQ_WAIT: begin
        mdu_cmd.start = mdu_stat.done;
        mdu_a         = abs_val(coeff_linear);
        mdu_b         = abs_val(xe);
      end
      S_ITER: begin
        mdu_cmd.start = (den_mag != '0);
        mdu_a         = abs_val(f1);
        mdu_b         = span_mag;
      end
      S_PMUL_WAIT: begin
        mdu_cmd.start = mdu_stat.done;
        mdu_cmd.op    = MDU_DIV;
        mdu_a         = den_mag;
      end
      S_TOL: begin
        mdu_cmd.start = 1'b1;
        mdu_a         = abs_val(x2);
        mdu_b         = W'(rel_tolerance);
      end
      default: ;
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          x1       <= s_tdata[W-1:0];
          x2       <= s_tdata[2*W-1:W];
          xe       <= s_tdata[W-1:0];
          x0       <= '0;
          count    <= '0;
          eval_sel <= EV_FIRST;
        end
      end
      S_SQ_WAIT:  if (mdu_stat.done) term_sq <= scaled;
      S_LIN_WAIT: if (mdu_stat.done) term_lin <= scaled;
      S_ADD1:     fsum <= sat_add(term_sq, term_lin);
      S_ADD2: begin
        case (eval_sel)
          EV_FIRST: begin
            f1       <= f_new;
            xe       <= x2;
            eval_sel <= EV_SECOND;
          end
          EV_SECOND: f2 <= f_new;
          default:   f0 <= f_new;
        endcase
      end
      S_SIGN: begin
        if (same_sign) begin
          x0     <= '0;
          result <= OUT_NO_SIGN;
        end else begin
          eval_sel <= EV_EST;
        end
      end
      S_ITER: begin
        count <= count + 1'b1;
        // Both ends zero: the estimate stays at the first end.
        if (den_mag == '0) begin
          x0 <= x1;
          xe <= x1;
        end
      end
      S_DIV_WAIT: begin
        if (mdu_stat.done) begin
          x0 <= x0_calc;
          xe <= x0_calc;
        end
      end
      S_UPDATE: begin
        if (f0 == '0) begin
          result <= OUT_EXACT;
        end else if (opposite) begin
          x2 <= x0;
          f2 <= f0;
        end else begin
          x1 <= x0;
          f1 <= f0;
        end
      end
      S_TOL_WAIT: begin
        if (mdu_stat.done) begin
          result <= tol_ok ? OUT_CONVERGED : OUT_LIMIT;
        end
      end
      default: ;
    endcase
  end

  // Output register: valid flag and payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      m_tdata <= OUT_W'({result, count, x0});
    end
  end

  // Checks on the sequencer and the shared unit.
  logic [W-1:0]         chk_root;
  logic [COUNT_W-1:0]   chk_count;
  logic [OUTCOME_W-1:0] chk_outcome;

  assign chk_root    = m_tdata[W-1:0];
  assign chk_count   = m_tdata[W+COUNT_W-1:W];
  assign chk_outcome = m_tdata[W+COUNT_W+OUTCOME_W-1:W+COUNT_W];

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    mdu_stat.done |-> $past(mdu_stat.busy))
    else $error("shared unit signaled done without a preceding operation");

  a_iter_unit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_ITER) |-> !mdu_stat.busy)
    else $error("iteration started while the shared unit was busy");

  a_no_sign_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (chk_outcome == OUT_NO_SIGN)) |-> ((chk_count == '0) && (chk_root == '0)))
    else $error("no sign change result with nonzero estimate or count");

  a_limit_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (chk_outcome == OUT_LIMIT)) |->
      ((chk_count == iteration_limit) || ((iteration_limit == '0) && (chk_count == 8'd1))))
    else $error("iteration limit result with a count other than the limit");

endmodule
